FILE: sv/bkts_pkg.sv
package bkts_pkg;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 7;
  localparam int FLAG_W   = 8;
  localparam int BN_W     = 9;
  localparam int ST_W     = 2;
  localparam int ENTRY_W  = 3 * KEY_W + FLAG_W;

  localparam int DEF_MAX_ENTRIES  = 256;
  localparam int DEF_MAX_PATTERNS = 128;

  localparam int Q_DEPTH = 2;

  localparam logic [FLAG_W-1:0] SPACE_FLAG = 8'd32;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOCATE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_PAT   = 2'd1;
  localparam logic [ST_W-1:0] ST_ORDER     = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  // One classified request as it travels from front to back.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  pattern;
    logic [KEY_W-1:0]  sub_pattern;
    logic [KEY_W-1:0]  priority_key;
    logic [FLAG_W-1:0] flag_key;
    logic              bad_pattern;
  } cmd_t;

endpackage

FILE: sv/bkts_ram.sv
module bkts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bkts_front.sv
module bkts_front #(
  parameter int MAX_PATTERNS = bkts_pkg::DEF_MAX_PATTERNS
) (
  input  logic [bkts_pkg::KIND_W-1:0] kind,
  input  logic [bkts_pkg::KEY_W-1:0]  pattern,
  input  logic [bkts_pkg::KEY_W-1:0]  sub_pattern,
  input  logic [bkts_pkg::KEY_W-1:0]  priority_key,
  input  logic [bkts_pkg::FLAG_W-1:0] flag_key,
  output bkts_pkg::cmd_t              cmd
);
  import bkts_pkg::*;

  always_comb begin
    cmd.kind         = kind;
    cmd.pattern      = pattern;
    cmd.sub_pattern  = sub_pattern;
    cmd.priority_key = priority_key;
    // Store a space flag as zero on load; queries compare the raw byte.
    if (kind == KIND_LOAD && flag_key == SPACE_FLAG) begin
      cmd.flag_key = '0;
    end else begin
      cmd.flag_key = flag_key;
    end
    cmd.bad_pattern = (pattern == '0) || (32'(pattern) > MAX_PATTERNS);
  end

endmodule

FILE: sv/bkts_queue.sv
module bkts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bkts_pkg::cmd_t cmd_in,
  output logic           full,
  input  logic           pop,
  output bkts_pkg::cmd_t cmd_out,
  output logic           empty
);
  import bkts_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  cmd_t          slots [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full    = (fill == CW'(Q_DEPTH));
  assign empty   = (fill == '0);
  assign cmd_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CW'(push && !full) - CW'(pop && !empty);
    end
  end

endmodule

FILE: sv/bkts_back.sv
module bkts_back #(
  parameter int MAX_ENTRIES  = bkts_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_PATTERNS = bkts_pkg::DEF_MAX_PATTERNS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  bkts_pkg::cmd_t            q_cmd,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bkts_pkg::BN_W-1:0] block_number,
  output logic [bkts_pkg::ST_W-1:0] status
);
  import bkts_pkg::*;

  localparam int IDW = $clog2(MAX_ENTRIES + 2);
  localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PAW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_QSTART = 3'd3;
  localparam logic [2:0] S_QEND   = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]       state;
  cmd_t             cmd;
  logic [IDW-1:0]   count;
  logic [KEY_W-1:0] hp;
  logic [KEY_W-1:0] k;
  logic [IDW-1:0]   id_new;
  logic [IDW-1:0]   j;
  logic [IDW-1:0]   end_id;
  logic             cmp_valid;
  logic [IDW-1:0]   res_id;
  logic [ST_W-1:0]  res_st;

  logic               ent_we;
  logic [EAW-1:0]     ent_waddr;
  logic [ENTRY_W-1:0] ent_wdata;
  logic [EAW-1:0]     ent_raddr;
  logic [ENTRY_W-1:0] ent_rdata;
  logic               bs_we;
  logic [PAW-1:0]     bs_waddr;
  logic [PAW-1:0]     bs_raddr;
  logic [IDW-1:0]     bs_rdata;

  logic [KEY_W-1:0]  pm1;
  logic [IDW-1:0]    jm1;
  logic              load_ok;
  logic              query_bad;
  logic              j_in;
  logic              hit;
  logic [KEY_W-1:0]  e_pattern;
  logic [KEY_W-1:0]  e_sub;
  logic [KEY_W-1:0]  e_prio;
  logic [FLAG_W-1:0] e_flag;

  bkts_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entries (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  bkts_ram #(.WIDTH(IDW), .DEPTH(MAX_PATTERNS)) u_buckets (
    .clk   (clk),
    .we    (bs_we),
    .waddr (bs_waddr),
    .wdata (id_new),
    .raddr (bs_raddr),
    .rdata (bs_rdata)
  );

  assign {e_pattern, e_sub, e_prio, e_flag} = ent_rdata;

  always_comb begin
    pm1       = cmd.pattern - 1'b1;
    jm1       = j - 1'b1;
    id_new    = count + 1'b1;
    load_ok   = !cmd.bad_pattern && !(cmd.pattern < hp) && (count != IDW'(MAX_ENTRIES));
    query_bad = (cmd.pattern == '0) || (cmd.pattern > hp);
    j_in      = (j < end_id) && (j != '0) && (j <= count);
    hit       = cmp_valid && (e_pattern == cmd.pattern) && (e_prio == cmd.priority_key) &&
                (e_flag == cmd.flag_key) &&
                ((cmd.kind == KIND_SCAN) || (e_sub == cmd.sub_pattern));

    q_pop     = (state == S_IDLE) && !q_empty;
    ent_we    = (state == S_EXEC) && (cmd.kind == KIND_LOAD) && load_ok;
    ent_waddr = count[EAW-1:0];
    ent_wdata = {cmd.pattern, cmd.sub_pattern, cmd.priority_key, cmd.flag_key};
    ent_raddr = jm1[EAW-1:0];
    bs_we     = (state == S_FILL);
    bs_waddr  = k[PAW-1:0];
    bs_raddr  = (state == S_QSTART) ? cmd.pattern[PAW-1:0] : pm1[PAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      cmd <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      hp        <= '0;
      k         <= '0;
      j         <= '0;
      end_id    <= '0;
      cmp_valid <= 1'b0;
      res_id    <= '0;
      res_st    <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd.kind)
            KIND_CLEAR: begin
              count  <= '0;
              hp     <= '0;
              res_id <= '0;
              res_st <= ST_OK;
              state  <= S_FINISH;
            end
            KIND_LOAD: begin
              if (cmd.bad_pattern) begin
                res_id <= '0;
                res_st <= ST_BAD_PAT;
                state  <= S_FINISH;
              end else if (cmd.pattern < hp) begin
                res_id <= '0;
                res_st <= ST_ORDER;
                state  <= S_FINISH;
              end else if (count == IDW'(MAX_ENTRIES)) begin
                res_id <= '0;
                res_st <= ST_FULL;
                state  <= S_FINISH;
              end else if (hp < cmd.pattern) begin
                k      <= hp;
                res_st <= ST_OK;
                state  <= S_FILL;
              end else begin
                count  <= id_new;
                res_id <= id_new;
                res_st <= ST_OK;
                state  <= S_FINISH;
              end
            end
            KIND_LOCATE, KIND_SCAN: begin
              res_id <= '0;
              if (query_bad) begin
                res_st <= ST_BAD_PAT;
                state  <= S_FINISH;
              end else begin
                res_st <= ST_OK;
                state  <= S_QSTART;
              end
            end
            default: begin
              state <= S_FINISH;
            end
          endcase
        end
        S_FILL: begin
          // Point every skipped pattern at the new entry, one a cycle.
          k <= k + 1'b1;
          if (k + 1'b1 == cmd.pattern) begin
            hp     <= cmd.pattern;
            count  <= id_new;
            res_id <= id_new;
            state  <= S_FINISH;
          end
        end
        S_QSTART: begin
          j         <= bs_rdata;
          cmp_valid <= 1'b0;
          if (cmd.pattern == hp) begin
            end_id <= count + 1'b1;
            state  <= S_WALK;
          end else begin
            state <= S_QEND;
          end
        end
        S_QEND: begin
          end_id <= bs_rdata;
          state  <= S_WALK;
        end
        S_WALK: begin
          // Compare the entry read last cycle while fetching the next one.
          if (hit) begin
            res_id <= j - 1'b1;
            state  <= S_FINISH;
          end else if (j_in) begin
            cmp_valid <= 1'b1;
            j         <= j + 1'b1;
          end else begin
            res_id <= '0;
            state  <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!out_valid || out_ready)) begin
      block_number <= BN_W'(res_id);
      status       <= res_st;
    end
  end

endmodule

FILE: sv/bucketed_key_table_search.sv
// Bucketed key table search. Send one request per item on the input channel:
// kind 0 clears the table, kind 1 loads an entry (patterns must arrive in
// non-decreasing order; ids are handed out 1, 2, 3 and so on), kind 2 locates
// an entry matching all four keys within its pattern's bucket, and kind 3
// returns the first entry matching pattern, priority and flag, ignoring the
// sub-pattern. Every request yields exactly one result: block_number (0 when
// nothing matches or on any error) and status (0 ok, 1 invalid pattern,
// 2 load out of order, 3 table full). A flag byte of space is stored as zero
// on load; query flags compare unchanged. Requests are handled one at a time
// by the back end; a two-deep request queue lets the input side keep
// accepting while the back end works or while a result waits on the output.
// Clear, failed loads and invalid queries go straight to the result
// register. A load past the previous highest pattern first writes the
// bucket index of each pattern index it passes (one bucket-index RAM write
// per cycle). A query reads its bucket's entries (one entry RAM read per
// cycle, compared the following cycle); one whose pattern is not the
// highest loaded also reads its bucket end from the index. The entry and
// bucket-index memories need no clearing pass after reset.
module bucketed_key_table_search #(
  parameter int MAX_ENTRIES  = bkts_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_PATTERNS = bkts_pkg::DEF_MAX_PATTERNS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bkts_pkg::KIND_W-1:0] kind,
  input  logic [bkts_pkg::KEY_W-1:0]  pattern,
  input  logic [bkts_pkg::KEY_W-1:0]  sub_pattern,
  input  logic [bkts_pkg::KEY_W-1:0]  priority_key,
  input  logic [bkts_pkg::FLAG_W-1:0] flag_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bkts_pkg::BN_W-1:0]   block_number,
  output logic [bkts_pkg::ST_W-1:0]   status
);
  import bkts_pkg::*;

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;

  // Classify the request: normalize the load flag, check the pattern range.
  bkts_front #(.MAX_PATTERNS(MAX_PATTERNS)) u_front (
    .kind         (kind),
    .pattern      (pattern),
    .sub_pattern  (sub_pattern),
    .priority_key (priority_key),
    .flag_key     (flag_key),
    .cmd          (front_cmd)
  );

  // Hold classified requests until the back end is free.
  assign in_ready = !q_full;

  bkts_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (in_valid),
    .cmd_in  (front_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (q_cmd),
    .empty   (q_empty)
  );

  // Execute loads and queries against the entry and bucket-index memories.
  bkts_back #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_PATTERNS (MAX_PATTERNS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .block_number (block_number),
    .status       (status)
  );

endmodule

FILE: bench/key_table_checker.sv
`timescale 1ns / 1ps
module key_table_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [bkts_pkg::KIND_W-1:0] kind,
  input  logic [bkts_pkg::KEY_W-1:0]  pattern,
  input  logic [bkts_pkg::KEY_W-1:0]  sub_pattern,
  input  logic [bkts_pkg::KEY_W-1:0]  priority_key,
  input  logic [bkts_pkg::FLAG_W-1:0] flag_key,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [bkts_pkg::BN_W-1:0]   block_number,
  input  logic [bkts_pkg::ST_W-1:0]   status,
  output int                          fail_count,
  output int                          pending,
  output int                          results_checked,
  output int                          hits_predicted,
  output logic [3:0]                  status_mask
);
  import bkts_pkg::*;

  localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
  localparam int PAT_SLOTS   = DEF_MAX_PATTERNS;

  typedef struct packed {
    logic [BN_W-1:0] block_number;
    logic [ST_W-1:0] status;
  } table_reply_t;

  table_reply_t replies_due[$];

  // Shadow of the table contents and the per-pattern first-id index.
  logic [KEY_W-1:0]  ent_pat  [0:TABLE_DEPTH-1];
  logic [KEY_W-1:0]  ent_sub  [0:TABLE_DEPTH-1];
  logic [KEY_W-1:0]  ent_pri  [0:TABLE_DEPTH-1];
  logic [FLAG_W-1:0] ent_flag [0:TABLE_DEPTH-1];
  logic [BN_W-1:0]   first_id [0:PAT_SLOTS-1];
  int unsigned       entries_held;
  int unsigned       top_pattern;

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    hits_predicted  = 0;
    status_mask     = '0;
    entries_held    = 0;
    top_pattern     = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic predict_reply(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] p,
                               input logic [KEY_W-1:0] sp, input logic [KEY_W-1:0] pr,
                               input logic [FLAG_W-1:0] fl, output table_reply_t r);
    int unsigned lo;
    int unsigned hi;
    int unsigned j;
    r.block_number = '0;
    r.status       = ST_OK;
    case (k)
      KIND_CLEAR: begin
        entries_held = 0;
        top_pattern  = 0;
      end
      KIND_LOAD: begin
        if (p == 0 || p > PAT_SLOTS) begin
          r.status = ST_BAD_PAT;
        end else if (p < top_pattern) begin
          r.status = ST_ORDER;
        end else if (entries_held >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ent_pat[entries_held]  = p;
          ent_sub[entries_held]  = sp;
          ent_pri[entries_held]  = pr;
          ent_flag[entries_held] = (fl == SPACE_FLAG) ? '0 : fl;
          // Point every pattern skipped over at the new entry.
          for (j = top_pattern; j < p; j++) first_id[j] = BN_W'(entries_held + 1);
          top_pattern    = p;
          entries_held   = entries_held + 1;
          r.block_number = BN_W'(entries_held);
        end
      end
      default: begin
        if (p == 0 || p > top_pattern) begin
          r.status = ST_BAD_PAT;
        end else begin
          lo = first_id[p - 1];
          hi = (p + 1 > top_pattern) ? entries_held + 1 : first_id[p];
          for (j = lo; j < hi; j++) begin
            if (j == 0 || j > entries_held) break;
            if (ent_pat[j-1] == p && ent_pri[j-1] == pr && ent_flag[j-1] == fl &&
                (k == KIND_SCAN || ent_sub[j-1] == sp)) begin
              r.block_number = BN_W'(j);
              break;
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    table_reply_t want;
    if (rst) begin
      replies_due.delete();
      entries_held = 0;
      top_pattern  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result with none outstanding, block_number", block_number, 0);
        end else begin
          want = replies_due.pop_front();
          results_checked++;
          if (block_number !== want.block_number)
            report_mismatch("block_number", block_number, want.block_number);
          if (status !== want.status)
            report_mismatch("status", status, want.status);
        end
      end
      if (in_valid && in_ready) begin
        predict_reply(kind, pattern, sub_pattern, priority_key, flag_key, want);
        if ((kind == KIND_LOCATE || kind == KIND_SCAN) && want.block_number != 0)
          hits_predicted++;
        status_mask[want.status] = 1'b1;
        replies_due.push_back(want);
      end
    end
    pending = replies_due.size();
  end

endmodule

FILE: bench/bucketed_key_table_search_tb.sv
`timescale 1ns / 1ps
module bucketed_key_table_search_tb;
  import bkts_pkg::*;

  // Start no new random episode once this many requests in all have gone in.
  localparam int RANDOM_ITEMS = 1650;

  // Keys of one request, as the stimulus side remembers loaded entries.
  typedef struct packed {
    logic [KEY_W-1:0]  p;
    logic [KEY_W-1:0]  sp;
    logic [KEY_W-1:0]  pr;
    logic [FLAG_W-1:0] fl;
  } key_set_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  pattern;
  logic [KEY_W-1:0]  sub_pattern;
  logic [KEY_W-1:0]  priority_key;
  logic [FLAG_W-1:0] flag_key;
  logic              out_valid;
  logic              out_ready;
  logic [BN_W-1:0]   block_number;
  logic [ST_W-1:0]   status;

  int         fail_count;
  int         pending;
  int         results_checked;
  int         hits_predicted;
  logic [3:0] status_mask;

  // Stimulus bookkeeping: what has been loaded since the last clear, so that
  // queries can aim at real entries. The checker alone decides pass or fail.
  key_set_t loaded_keys[$];
  int       hi_pat;
  int       sent_count;
  int       burst_left;
  int       episode;

  bucketed_key_table_search uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .pattern      (pattern),
    .sub_pattern  (sub_pattern),
    .priority_key (priority_key),
    .flag_key     (flag_key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .block_number (block_number),
    .status       (status)
  );

  key_table_checker table_watch (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .pattern         (pattern),
    .sub_pattern     (sub_pattern),
    .priority_key    (priority_key),
    .flag_key        (flag_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .block_number    (block_number),
    .status          (status),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .hits_predicted  (hits_predicted),
    .status_mask     (status_mask)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Pick keys that collide often (tiny ranges, zero, space, all ones) but
  // still sweep every bit now and then.
  function automatic key_set_t random_keys(input int p);
    key_set_t r;
    r.p  = KEY_W'(p);
    r.sp = KEY_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 127));
    r.pr = KEY_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 127));
    case ($urandom_range(0, 4))
      0:       r.fl = '0;
      1:       r.fl = SPACE_FLAG;
      2:       r.fl = '1;
      3:       r.fl = FLAG_W'($urandom_range(0, 3));
      default: r.fl = FLAG_W'($urandom_range(0, 255));
    endcase
    return r;
  endfunction

  // Offer one request at the falling edge, hold it until accepted, then
  // either go straight on to the next one or end the burst with a gap.
  task automatic send_request(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] p,
                              input logic [KEY_W-1:0] sp, input logic [KEY_W-1:0] pr,
                              input logic [FLAG_W-1:0] fl);
    key_set_t e;
    @(negedge clk);
    kind         <= k;
    pattern      <= p;
    sub_pattern  <= sp;
    priority_key <= pr;
    flag_key     <= fl;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    // Track what the table should now hold, for aiming queries only.
    if (k == KIND_CLEAR) begin
      loaded_keys.delete();
      hi_pat = 0;
    end else if (k == KIND_LOAD && p != 0 && p >= hi_pat &&
                 loaded_keys.size() < DEF_MAX_ENTRIES) begin
      e.p  = p;
      e.sp = sp;
      e.pr = pr;
      e.fl = (fl == SPACE_FLAG) ? '0 : fl;
      loaded_keys.push_back(e);
      hi_pat = p;
    end
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
  endtask

  // Aim at a loaded entry, or ask for random keys with a pattern in the loaded range.
  task automatic send_query(input bit want_hit);
    key_set_t e;
    int       idx;
    if (want_hit && loaded_keys.size() != 0) begin
      idx = $urandom_range(0, loaded_keys.size() - 1);
      e   = loaded_keys[idx];
      if ($urandom_range(0, 1))
        send_request(KIND_LOCATE, e.p, e.sp, e.pr, e.fl);
      else
        send_request(KIND_SCAN, e.p, KEY_W'($urandom_range(0, 127)), e.pr, e.fl);
    end else begin
      e = random_keys(hi_pat == 0 ? $urandom_range(1, 127) : $urandom_range(1, hi_pat));
      send_request($urandom_range(0, 1) ? KIND_LOCATE : KIND_SCAN, e.p, e.sp, e.pr, e.fl);
    end
  endtask

  // Stop offering and wait until every outstanding result is back.
  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: hold off once for a long stretch after a few hundred
  // requests so the queue fills and in_ready drops; otherwise cycle through
  // stall modes of random length.
  initial begin : result_sink
    int mode;
    int mode_left;
    int held;
    int tick;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    held      = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (sent_count >= 300 && held < 250) begin
        held++;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 2) == 0);
          default: out_ready <= ((tick % 5) < 3);
        endcase
      end
    end
  end

  initial begin : stimulus
    key_set_t e;
    bit       fill_table;
    bit       flat;
    int       loads_left;
    int       cur_p;
    int       roll;

    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_CLEAR;
    pattern      = '0;
    sub_pattern  = '0;
    priority_key = '0;
    flag_key     = '0;
    hi_pat       = 0;
    sent_count   = 0;
    episode      = 0;
    burst_left   = $urandom_range(1, 24);

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: empty table, bad and out-of-order loads, field extremes,
    // space flag folding, empty buckets, the top pattern, clear.
    send_request(KIND_LOCATE, 7'd5, 7'd0, 7'd0, 8'd0);       // query on empty table
    send_request(KIND_LOAD, 7'd0, 7'd1, 7'd1, 8'd1);         // pattern zero load
    send_request(KIND_LOAD, 7'd1, 7'd0, 7'd0, 8'd0);
    send_request(KIND_LOAD, 7'd1, 7'd127, 7'd127, 8'd255);
    send_request(KIND_LOAD, 7'd3, 7'd5, 7'd9, SPACE_FLAG);   // stored as zero
    send_request(KIND_LOAD, 7'd3, 7'd6, 7'd9, 8'd0);
    send_request(KIND_LOAD, 7'd2, 7'd0, 7'd0, 8'd0);         // below highest pattern
    send_request(KIND_LOCATE, 7'd1, 7'd0, 7'd0, 8'd0);
    send_request(KIND_LOCATE, 7'd1, 7'd127, 7'd127, 8'd255);
    send_request(KIND_LOCATE, 7'd3, 7'd5, 7'd9, 8'd0);       // hits the folded space
    send_request(KIND_LOCATE, 7'd3, 7'd5, 7'd9, SPACE_FLAG); // query flag not folded
    send_request(KIND_SCAN, 7'd3, 7'd100, 7'd9, 8'd0);       // first of two matches
    send_request(KIND_LOCATE, 7'd3, 7'd6, 7'd9, 8'd0);
    send_request(KIND_LOCATE, 7'd2, 7'd0, 7'd0, 8'd0);       // empty bucket
    send_request(KIND_SCAN, 7'd4, 7'd0, 7'd9, 8'd0);         // above highest pattern
    send_request(KIND_SCAN, 7'd0, 7'd0, 7'd0, 8'd0);
    send_request(KIND_LOAD, 7'd127, 7'd42, 7'd85, 8'd170);   // fill the index gap
    send_request(KIND_LOCATE, 7'd127, 7'd42, 7'd85, 8'd170);
    send_request(KIND_SCAN, 7'd127, 7'd0, 7'd85, 8'd170);
    send_request(KIND_LOCATE, 7'd3, 7'd6, 7'd9, 8'd0);       // bucket end from index
    send_request(KIND_CLEAR, 7'd127, 7'd127, 7'd127, 8'd255);
    send_request(KIND_LOCATE, 7'd1, 7'd0, 7'd0, 8'd0);       // table empty again
    send_request(KIND_LOAD, 7'd1, 7'd3, 7'd3, SPACE_FLAG);
    send_request(KIND_SCAN, 7'd1, 7'd0, 7'd3, 8'd0);
    drain_results();

    // Random episodes: clear (mostly), load an ordered run with queries and
    // noise mixed in, finish with a few queries. Some episodes fill the table.
    while (sent_count < RANDOM_ITEMS) begin
      episode++;
      fill_table = (episode == 2) || ($urandom_range(0, 24) == 0);
      if (fill_table || $urandom_range(0, 4) != 0) begin
        e = random_keys($urandom_range(0, 127));
        send_request(KIND_CLEAR, e.p, e.sp, e.pr, e.fl);
      end
      loads_left = fill_table ? DEF_MAX_ENTRIES + 4 : $urandom_range(1, 30);
      flat       = !fill_table && ($urandom_range(0, 7) == 0);
      cur_p      = (hi_pat == 0) ? $urandom_range(1, 6) : hi_pat;
      while (loads_left > 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          if (cur_p < hi_pat) cur_p = hi_pat;
          e = random_keys(cur_p);
          send_request(KIND_LOAD, e.p, e.sp, e.pr, e.fl);
          loads_left--;
          // Advance mostly by one, sometimes stay, now and then leap ahead.
          if (!flat) begin
            if ($urandom_range(0, 19) == 0) cur_p += $urandom_range(2, 40);
            else if ($urandom_range(0, 3) != 0) cur_p++;
            if (cur_p > 127) cur_p = 127;
          end
        end else if (roll < 80) begin
          send_query(1'b1);
        end else if (roll < 88) begin
          send_query(1'b0);
        end else if (roll < 93) begin
          // Broken load: pattern zero or below the highest one.
          if (hi_pat < 2 || $urandom_range(0, 1))
            e = random_keys(0);
          else
            e = random_keys($urandom_range(1, hi_pat - 1));
          send_request(KIND_LOAD, e.p, e.sp, e.pr, e.fl);
        end else if (roll < 96) begin
          if (hi_pat >= 127 || $urandom_range(0, 1))
            e = random_keys(0);
          else
            e = random_keys($urandom_range(hi_pat + 1, 127));
          send_request($urandom_range(0, 1) ? KIND_LOCATE : KIND_SCAN,
                       e.p, e.sp, e.pr, e.fl);
        end else if (!fill_table) begin
          // Pure noise, any kind and any field.
          send_request(KIND_W'($urandom_range(0, 3)), KEY_W'($urandom_range(0, 127)),
                       KEY_W'($urandom_range(0, 127)), KEY_W'($urandom_range(0, 127)),
                       FLAG_W'($urandom_range(0, 255)));
        end else begin
          send_query(1'b0);
        end
      end
      repeat ($urandom_range(3, 15)) send_query($urandom_range(0, 3) != 0);
      if (episode % 4 == 0) drain_results();
    end

    // Let everything drain, then give stray results a chance to show up.
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d requests in %0d table episodes; %0d results checked, %0d query hits",
             sent_count, episode, results_checked, hits_predicted);
    $display("status codes seen (full, order, bad pattern, ok): %b", status_mask);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: bucketed_key_table_search.f
sv/bkts_pkg.sv
sv/bkts_ram.sv
sv/bkts_front.sv
sv/bkts_queue.sv
sv/bkts_back.sv
sv/bucketed_key_table_search.sv
bench/key_table_checker.sv
bench/bucketed_key_table_search_tb.sv
